### rtl/core/rrbc_pkg.sv
package rrbc_pkg;

  // Input transaction: one bus access or one ROM image byte
  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] cpu_address;
    logic [7:0]  data_byte;
    logic [18:0] rom_offset;
  } in_item_t;

  // Result transaction
  typedef struct packed {
    logic [7:0] read_data;
    logic       ok;
  } out_item_t;

  // Transaction kinds
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_LOAD   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_t;

  // Source of the byte returned by the read stage
  typedef enum logic [1:0] {
    SRC_NONE = 2'd0,
    SRC_ROM  = 2'd1,
    SRC_RAM  = 2'd2
  } src_t;

  // 8 KiB address regions, taken from cpu_address[15:13]
  localparam logic [2:0] REGION_RAM_EN   = 3'b000;
  localparam logic [2:0] REGION_LOW_BANK = 3'b001;
  localparam logic [2:0] REGION_HIGH     = 3'b010;
  localparam logic [2:0] REGION_MODE_SEL = 3'b011;
  localparam logic [2:0] REGION_SAVE_RAM = 3'b101;

  // 16 KiB ROM windows, taken from cpu_address[15:14]
  localparam logic [1:0] WINDOW_ROM_FIXED  = 2'b00;
  localparam logic [1:0] WINDOW_ROM_BANKED = 2'b01;

  // Control data codes
  localparam logic [3:0] RAM_EN_KEY   = 4'hA;
  localparam logic [7:0] SEL_ROM_MODE = 8'h00;
  localparam logic [7:0] SEL_RAM_MODE = 8'h01;

  localparam int ROM_BANK_BYTES = 16384;
  localparam int RAM_BANK_BYTES = 8192;

endpackage

### rtl/core/rrbc_ram.sv
module rrbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/rom_ram_bank_controller.sv
// Cartridge bank controller: banked ROM and banked save RAM on a 16-bit bus.
// A transaction passes through the memory read stage, then the
// output register. Throughput: one transaction per cycle while the output
// is not stalled, set by the single read and write port of each memory.
// Reset: control registers return to ROM mode, bank 0, RAM disabled; the
// save RAM is then cleared with in_ready low.
module rom_ram_bank_controller
  import rrbc_pkg::*;
#(
  parameter int ROM_BANKS = 32,
  parameter int RAM_BANKS = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int ROM_BYTES = ROM_BANKS * ROM_BANK_BYTES;
  localparam int RAM_BYTES = RAM_BANKS * RAM_BANK_BYTES;
  localparam int ROM_AW    = $clog2(ROM_BYTES);
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  // Control registers
  logic       ram_enable_r, ram_enable_nxt;
  logic [4:0] low_bank_r,   low_bank_nxt;
  logic [1:0] high_bits_r,  high_bits_nxt;
  logic       rom_mode_r,   rom_mode_nxt;

  // Clearing sweep
  logic              clearing_r, clearing_nxt;
  logic [RAM_AW-1:0] clr_addr_r, clr_addr_nxt;

  // Read stage and output register
  logic      s1_valid_r, s1_valid_nxt;
  src_t      s1_src_r,   s1_src_nxt;
  logic      s1_ok_r,    s1_ok_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r,  out_item_nxt;

  logic accept;
  logic s1_adv;

  // Bank wrap tables, worked out at elaboration
  logic [6:0] rom_bank_lut [128];
  logic [1:0] ram_bank_lut [4];

  for (genvar g = 0; g < 128; g++) begin : g_rom_lut
    assign rom_bank_lut[g] = 7'(g % ROM_BANKS);
  end

  for (genvar g = 0; g < 4; g++) begin : g_ram_lut
    assign ram_bank_lut[g] = 2'(g % RAM_BANKS);
  end

  // Memory ports
  logic              rom_we, rom_re;
  logic [ROM_AW-1:0] rom_waddr, rom_raddr;
  logic [7:0]        rom_rdata;
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic [4:0]  eff_low;
  logic [1:0]  eff_high;
  logic [6:0]  rom_bank;
  logic [1:0]  ram_bank;
  logic [21:0] off_ext;
  logic        load_in_range;

  // Handshake: read stage drains into the output register
  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !clearing_r && (!s1_valid_r || s1_adv);
  assign accept   = in_valid && in_ready;

  // Current bank selection
  assign eff_low  = (low_bank_r == 5'd0) ? 5'd1 : low_bank_r;
  assign eff_high = rom_mode_r ? high_bits_r : 2'd0;
  assign rom_bank = rom_bank_lut[{eff_high, eff_low}];
  assign ram_bank = rom_mode_r ? 2'd0 : ram_bank_lut[high_bits_r];

  assign off_ext       = {3'd0, in_item.rom_offset};
  assign load_in_range = off_ext < 22'(ROM_BYTES);

  // Decode the transaction: memory accesses, register updates, read stage
  always_comb begin
    rom_we         = 1'b0;
    rom_re         = 1'b0;
    rom_waddr      = ROM_AW'(in_item.rom_offset);
    rom_raddr      = ROM_AW'({7'd0, in_item.cpu_address[13:0]});
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_waddr      = RAM_AW'({ram_bank, in_item.cpu_address[12:0]});
    ram_raddr      = RAM_AW'({ram_bank, in_item.cpu_address[12:0]});
    ram_wdata      = in_item.data_byte;
    ram_enable_nxt = ram_enable_r;
    low_bank_nxt   = low_bank_r;
    high_bits_nxt  = high_bits_r;
    rom_mode_nxt   = rom_mode_r;
    s1_src_nxt     = SRC_NONE;
    s1_ok_nxt      = 1'b1;

    if (accept) begin
      case (in_item.mode)
        MODE_READ: begin
          case (in_item.cpu_address[15:14])
            WINDOW_ROM_FIXED: begin
              rom_re     = 1'b1;
              s1_src_nxt = SRC_ROM;
            end
            WINDOW_ROM_BANKED: begin
              rom_re     = 1'b1;
              rom_raddr  = ROM_AW'({rom_bank, in_item.cpu_address[13:0]});
              s1_src_nxt = SRC_ROM;
            end
            default: begin
              if (in_item.cpu_address[15:13] == REGION_SAVE_RAM && ram_enable_r) begin
                ram_re     = 1'b1;
                s1_src_nxt = SRC_RAM;
              end
            end
          endcase
        end
        MODE_WRITE: begin
          case (in_item.cpu_address[15:13])
            REGION_RAM_EN:   ram_enable_nxt = (in_item.data_byte[3:0] == RAM_EN_KEY);
            REGION_LOW_BANK: low_bank_nxt   = in_item.data_byte[4:0];
            REGION_HIGH:     high_bits_nxt  = in_item.data_byte[1:0];
            REGION_MODE_SEL: begin
              if (in_item.data_byte == SEL_ROM_MODE) begin
                rom_mode_nxt = 1'b1;
              end else if (in_item.data_byte == SEL_RAM_MODE) begin
                rom_mode_nxt = 1'b0;
              end
            end
            REGION_SAVE_RAM: ram_we = ram_enable_r;
            default: ;
          endcase
        end
        MODE_LOAD: begin
          rom_we    = load_in_range;
          s1_ok_nxt = load_in_range;
        end
        default: ;
      endcase
    end

    // Clearing sweep owns the RAM write port
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = 8'd0;
    end
  end

  // Advance the clearing sweep
  always_comb begin
    clearing_nxt = clearing_r;
    clr_addr_nxt = clr_addr_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == RAM_AW'(RAM_BYTES - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  // Read stage and output register flow
  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
      out_item_nxt.ok = s1_ok_r;
      case (s1_src_r)
        SRC_ROM: out_item_nxt.read_data = rom_rdata;
        SRC_RAM: out_item_nxt.read_data = ram_rdata;
        default: out_item_nxt.read_data = 8'd0;
      endcase
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_enable_r <= 1'b0;
      low_bank_r   <= 5'd0;
      high_bits_r  <= 2'd0;
      rom_mode_r   <= 1'b1;
      clearing_r   <= 1'b1;
      clr_addr_r   <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ram_enable_r <= ram_enable_nxt;
      low_bank_r   <= low_bank_nxt;
      high_bits_r  <= high_bits_nxt;
      rom_mode_r   <= rom_mode_nxt;
      clearing_r   <= clearing_nxt;
      clr_addr_r   <= clr_addr_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload: load only when a transaction enters or leaves the read stage
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_src_r <= s1_src_nxt;
      s1_ok_r  <= s1_ok_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  rrbc_ram #(
    .WIDTH (8),
    .DEPTH (ROM_BYTES)
  ) u_rom (
    .clk   (clk),
    .we    (rom_we),
    .waddr (rom_waddr),
    .wdata (in_item.data_byte),
    .re    (rom_re),
    .raddr (rom_raddr),
    .rdata (rom_rdata)
  );

  rrbc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_BYTES)
  ) u_save_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import rrbc_pkg::*;

  localparam int ROM_BANKS = 32;
  localparam int RAM_BANKS = 4;
  localparam int ROM_BYTES = ROM_BANKS * ROM_BANK_BYTES;
  localparam int RAM_BYTES = RAM_BANKS * RAM_BANK_BYTES;
  localparam int RANDOM_ACCESSES = 874;
  localparam int CYCLE_LIMIT = 400000;

  // Cartridge state mirror and queue of expected bus results
  class cart_scoreboard;
    bit [7:0]    rom_img [int unsigned];
    int unsigned bank_loads [ROM_BANKS][$];
    bit [7:0]    save_ram [RAM_BYTES];
    bit          ram_on;
    bit [4:0]    low_bank;
    bit [1:0]    high_bits;
    bit          rom_mode;
    out_item_t   expected_reads [$];
    int          errors;

    function new();
      rom_mode = 1'b1;
    endfunction

    // Bank seen through the switchable ROM window
    function int unsigned rom_bank();
      int unsigned lo;
      int unsigned hi;
      lo = (low_bank == 0) ? 1 : low_bank;
      hi = rom_mode ? high_bits : 0;
      return ((hi << 5) + lo) % ROM_BANKS;
    endfunction

    function int unsigned ram_index(logic [15:0] a);
      int unsigned bank;
      bank = rom_mode ? 0 : high_bits % RAM_BANKS;
      return (bank * RAM_BANK_BYTES + a[12:0]) % RAM_BYTES;
    endfunction

    function bit [7:0] rom_byte(int unsigned idx);
      int unsigned i;
      i = idx % ROM_BYTES;
      return rom_img.exists(i) ? rom_img[i] : 8'h00;
    endfunction

    // Advance the mirror by one transaction and return the result it gives
    function out_item_t apply_access(in_item_t it);
      out_item_t   res;
      logic [15:0] a;
      a = it.cpu_address;
      res.read_data = 8'h00;
      res.ok = 1'b1;
      case (it.mode)
        MODE_READ: begin
          if (a[15:14] == WINDOW_ROM_FIXED)
            res.read_data = rom_byte(a[13:0]);
          else if (a[15:14] == WINDOW_ROM_BANKED)
            res.read_data = rom_byte(rom_bank() * ROM_BANK_BYTES + a[13:0]);
          else if (a[15:13] == REGION_SAVE_RAM && ram_on)
            res.read_data = save_ram[ram_index(a)];
        end
        MODE_WRITE: begin
          case (a[15:13])
            REGION_RAM_EN:   ram_on = (it.data_byte[3:0] == RAM_EN_KEY);
            REGION_LOW_BANK: low_bank = it.data_byte[4:0];
            REGION_HIGH:     high_bits = it.data_byte[1:0];
            REGION_MODE_SEL: begin
              if (it.data_byte == SEL_ROM_MODE) rom_mode = 1'b1;
              else if (it.data_byte == SEL_RAM_MODE) rom_mode = 1'b0;
            end
            REGION_SAVE_RAM: begin
              if (ram_on) save_ram[ram_index(a)] = it.data_byte;
            end
            default: ;
          endcase
        end
        MODE_LOAD: begin
          if (it.rom_offset < ROM_BYTES) begin
            rom_img[it.rom_offset] = it.data_byte;
            bank_loads[it.rom_offset / ROM_BANK_BYTES].push_back(it.rom_offset);
          end else begin
            res.ok = 1'b0;
          end
        end
        default: ;
      endcase
      return res;
    endfunction

    function void note_access(in_item_t it);
      expected_reads.push_back(apply_access(it));
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_reads.size() == 0) begin
        $error("unexpected result: read_data %02h ok %0b", got.read_data, got.ok);
        errors++;
        return;
      end
      want = expected_reads.pop_front();
      if (got.read_data !== want.read_data) begin
        $error("read_data: expected %02h, actual %02h", want.read_data, got.read_data);
        errors++;
      end
      if (got.ok !== want.ok) begin
        $error("ok: expected %0b, actual %0b", want.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  cart_scoreboard sb = new();
  int             n_sent = 0;
  int             n_cycles = 0;

  rom_ram_bank_controller #(
    .ROM_BANKS(ROM_BANKS),
    .RAM_BANKS(RAM_BANKS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item)
  );

  always #5 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  // Result side: random stalls, a quiet stretch, and one long hold-off
  initial begin
    int hold;
    bit held;
    hold = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (!held && n_sent >= 520) begin
        held = 1'b1;
        hold = 300;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (n_sent >= 250 && n_sent < 420) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 11);
      end
    end
  end

  function automatic in_item_t mk(mode_t m, logic [15:0] a, logic [7:0] d,
                                  logic [18:0] off);
    in_item_t it;
    it.mode = m;
    it.cpu_address = a;
    it.data_byte = d;
    it.rom_offset = off;
    return it;
  endfunction

  // Offset into save RAM, mostly in a small patch so reads find stored bytes
  function automatic logic [12:0] ram_offset();
    return ($urandom_range(9) < 7) ? 13'($urandom_range(31)) : 13'($urandom);
  endfunction

  function automatic logic [15:0] unmapped_address();
    return $urandom_range(1) ? {3'b100, 13'($urandom)}
                             : 16'($urandom_range(16'hC000, 16'hFFFF));
  endfunction

  // Build the next random transaction from the live cartridge state
  function automatic in_item_t pick_access();
    in_item_t    it;
    int unsigned roll;
    int unsigned bank;
    int unsigned n;
    int unsigned off;
    it = mk(MODE_READ, 16'($urandom), 8'($urandom), 19'($urandom));
    roll = $urandom_range(99);
    if (roll < 18) begin
      it.mode = MODE_LOAD;
      // keep some loads in the live bank so banked reads find data
      if ($urandom_range(1))
        it.rom_offset = 19'(sb.rom_bank() * ROM_BANK_BYTES
                            + $urandom_range(ROM_BANK_BYTES - 1));
    end else if (roll < 23) begin
      it.mode = MODE_UNUSED;
    end else if (roll < 58) begin
      case ($urandom_range(4))
        0, 1: begin
          bank = ($urandom_range(1) == 0) ? 0 : sb.rom_bank();
          n = sb.bank_loads[bank].size();
          if (n == 0) begin
            // nothing loaded here yet: load a byte instead of reading garbage
            it.mode = MODE_LOAD;
            it.rom_offset = 19'(bank * ROM_BANK_BYTES
                                + $urandom_range(ROM_BANK_BYTES - 1));
          end else begin
            off = sb.bank_loads[bank][$urandom_range(n - 1)];
            it.cpu_address = {(bank == 0) ? WINDOW_ROM_FIXED : WINDOW_ROM_BANKED,
                              off[13:0]};
          end
        end
        2, 3: it.cpu_address = {REGION_SAVE_RAM, ram_offset()};
        default: it.cpu_address = unmapped_address();
      endcase
    end else begin
      it.mode = MODE_WRITE;
      case ($urandom_range(9))
        0, 1: begin
          it.cpu_address = {REGION_RAM_EN, 13'($urandom)};
          if ($urandom_range(9) < 7) it.data_byte[3:0] = RAM_EN_KEY;
        end
        2: it.cpu_address = {REGION_LOW_BANK, 13'($urandom)};
        3: it.cpu_address = {REGION_HIGH, 13'($urandom)};
        4: begin
          it.cpu_address = {REGION_MODE_SEL, 13'($urandom)};
          case ($urandom_range(2))
            0: it.data_byte = SEL_ROM_MODE;
            1: it.data_byte = SEL_RAM_MODE;
            default: ;
          endcase
        end
        9: it.cpu_address = unmapped_address();
        default: it.cpu_address = {REGION_SAVE_RAM, ram_offset()};
      endcase
    end
    return it;
  endfunction

  // Offer one transaction, with an occasional idle gap, and hold it until taken
  task automatic send_access(input in_item_t it);
    while (!(n_sent >= 250 && n_sent < 420) && $urandom_range(99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_access(it);
    n_sent++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ROM image ends, window edges, RAM enable and mode switching.
    // With 32 banks the 19-bit offset cannot reach past the ROM, so every
    // load is in range.
    send_access(mk(MODE_LOAD, 16'($urandom), 8'hFF, 19'h00000));
    send_access(mk(MODE_LOAD, 16'($urandom), 8'h00, 19'h7FFFF));
    send_access(mk(MODE_LOAD, 16'($urandom), 8'h5A, 19'h07FFF));
    send_access(mk(MODE_READ, 16'h0000, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_UNUSED, 16'($urandom), 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_READ, 16'h8000, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_READ, 16'hA000, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_READ, 16'hFFFF, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h1FFF, 8'h1A, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'hA000, 8'hFF, 19'($urandom)));
    send_access(mk(MODE_READ, 16'hA000, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h3FFF, 8'h00, 19'($urandom)));
    send_access(mk(MODE_READ, 16'h7FFF, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h2000, 8'hFF, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h7FFF, SEL_RAM_MODE, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h4000, 8'hFF, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'hBFFF, 8'h77, 19'($urandom)));
    send_access(mk(MODE_READ, 16'hBFFF, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h6000, 8'h02, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h6000, SEL_ROM_MODE, 19'($urandom)));
    send_access(mk(MODE_READ, 16'h7FFF, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_READ, 16'hBFFF, 8'($urandom), 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h0000, 8'h00, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'hA000, 8'h33, 19'($urandom)));
    send_access(mk(MODE_WRITE, 16'h9FFF, 8'hAA, 19'($urandom)));
    send_access(mk(MODE_READ, 16'hA000, 8'($urandom), 19'($urandom)));

    // Random traffic
    for (int i = 0; i < RANDOM_ACCESSES; i++) send_access(pick_access());
    in_valid <= 1'b0;

    // Drain, then allow for any stray result
    while (sb.expected_reads.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/rrbc_pkg.sv
rtl/core/rrbc_ram.sv
rtl/core/rom_ram_bank_controller.sv
sim/tb.sv
